>>> sv/sd_card_spi_host_controller_core_defines.svh
// Assertion macros shared by the SD SPI host RTL.
// Depends on nothing; included by files that assert.
`ifndef SD_CARD_SPI_HOST_CONTROLLER_CORE_DEFINES_SVH
`define SD_CARD_SPI_HOST_CONTROLLER_CORE_DEFINES_SVH
// implication checked on every rising edge outside reset
`define SDH_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("sdh check failed");
// implication checked in the cycle after the antecedent
`define SDH_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("sdh check failed");
`endif

>>> sv/sdh_pkg.sv
// Shared types and constants for the SD SPI host.
// No dependencies.
`default_nettype none
package sdh_pkg;
  typedef enum logic [3:0] {
    PH_IDLE, PH_BOOT, PH_BUSY, PH_FRAME, PH_POLL, PH_RESP, PH_PAUSE, PH_TOKEN,
    PH_DATA, PH_CRC
  } phase_t;
  typedef enum logic [3:0] {
    SQ_RESET, SQ_COND, SQ_OP_PRE, SQ_OP, SQ_OCR, SQ_DET_PRE, SQ_DET, SQ_BLKLEN,
    SQ_CSD, SQ_READ
  } seq_t;
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_BYTE  = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;
  localparam logic [2:0] REG_RETRY = 3'd0;
  localparam logic [2:0] REG_BUSY  = 3'd1;
  localparam logic [2:0] REG_TOKEN = 3'd2;
  localparam logic [2:0] REG_POLL  = 3'd3;
  localparam logic [2:0] REG_BOOT  = 3'd4;
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_NO_RESP = 4'd1;
  localparam logic [3:0] ST_BUSY_TO = 4'd2;
  localparam logic [3:0] ST_RESET_FAIL = 4'd3;
  localparam logic [3:0] ST_CHECK_FAIL = 4'd4;
  localparam logic [3:0] ST_OP_FAIL = 4'd5;
  localparam logic [3:0] ST_REJECTED = 4'd6;
  localparam logic [3:0] ST_TOKEN_TO = 4'd7;
  localparam logic [3:0] ST_NOT_READY = 4'd8;
  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        select_active;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        data_last;
    logic        done_res;
    logic [3:0]  status;
    logic [38:0] card_blocks;
    logic        high_capacity;
    logic        fast_clock;
  } result_t;
endpackage
`default_nettype wire

>>> sv/sdh_csd_decode.sv
// CSD size decode: card capacity in 512-byte blocks from the 16 CSD bytes.
// Depends on no other file; sdh_pkg is not used.
`default_nettype none
module sdh_csd_decode (
  input  wire logic [127:0] csd,
  output logic [38:0]       blocks
);
  logic [7:0]  b [16];
  logic [3:0]  bl;
  logic [2:0]  mult;
  logic [12:0] c1;
  logic [5:0]  sh;
  logic [46:0] prod;
  logic [22:0] c2;
  logic [28:0] c3;

  always_comb begin
    for (int i = 0; i < 16; i++) b[i] = csd[127 - 8*i -: 8];
  end

  // version 1: (C_SIZE+1) << (MULT+2+READ_BL_LEN), then bytes to blocks
  assign bl   = b[5][3:0];
  assign mult = {b[9][1:0], b[10][7]};
  assign c1   = {1'b0, b[6][1:0], b[7], b[8][7:6]} + 13'd1;
  assign sh   = 6'(mult) + 6'd2 + 6'(bl);
  assign prod = 47'(c1) << sh;
  assign c2   = {1'b0, b[7][5:0], b[8], b[9]} + 23'd1;
  assign c3   = {1'b0, b[6][3:0], b[7], b[8], b[9]} + 29'd1;

  always_comb begin
    case (b[0][7:6])
      2'd0:    blocks = 39'(prod >> 9);
      2'd1:    blocks = {6'd0, c2, 10'd0};
      2'd2:    blocks = {c3, 10'd0};
      default: blocks = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/sdh_seq.sv
// Sequencer: one item per cycle while step is high, state updated and result formed in one pass.
// Depends on sdh_pkg, sdh_csd_decode and the defines header.
`default_nettype none
`include "sd_card_spi_host_controller_core_defines.svh"
module sdh_seq (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [1:0]   kind,
  input  wire logic [31:0]  sector,
  input  wire logic [7:0]   rx_byte,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_idx,
  input  wire logic [31:0]  cfg_data,
  output logic              res_has,
  output sdh_pkg::result_t  res
);
  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  // configuration
  logic [7:0]  retry_limit, boot_bytes;
  logic [23:0] busy_timeout, token_timeout, poll_interval;
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= 8'd10; busy_timeout <= 24'd1000000; token_timeout <= 24'd100000;
      poll_interval <= 24'd10000; boot_bytes <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sdh_pkg::REG_RETRY: retry_limit <= cfg_data[7:0];
        sdh_pkg::REG_BUSY:  busy_timeout <= cfg_data[23:0];
        sdh_pkg::REG_TOKEN: token_timeout <= cfg_data[23:0];
        sdh_pkg::REG_POLL:  poll_interval <= cfg_data[23:0];
        sdh_pkg::REG_BOOT:  boot_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // state registers and next values
  sdh_pkg::phase_t phase, phase_next;
  sdh_pkg::seq_t   seq, seq_next;
  logic [9:0]  byte_count, byte_count_next;
  logic [7:0]  resend_count, resend_count_next, poll_count, poll_count_next;
  logic [7:0]  reset_tries, reset_tries_next, r1_hold, r1_hold_next;
  logic [23:0] elapsed_ticks, elapsed_ticks_next, op_ticks, op_ticks_next;
  logic [47:0] command_frame, command_frame_next;
  logic [31:0] response_bytes, response_bytes_next;
  logic [2:0]  resp_len, resp_len_next;
  logic        capacity_flag, capacity_flag_next, ready_flag, ready_flag_next;
  logic        fast_flag, fast_flag_next, op_first, op_first_next;
  logic [38:0] block_total, block_total_next;
  logic [127:0] csd, csd_next;
  logic [38:0] csd_blocks;
  sdh_pkg::result_t o;
  logic has;

  sdh_csd_decode u_csd (.csd(csd), .blocks(csd_blocks));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sdh_pkg::PH_IDLE; seq <= sdh_pkg::SQ_RESET; byte_count <= '0;
      resend_count <= '0; poll_count <= '0; reset_tries <= '0; r1_hold <= '0;
      elapsed_ticks <= '0; op_ticks <= '0; command_frame <= '0; response_bytes <= '0;
      resp_len <= '0; capacity_flag <= 1'b0; ready_flag <= 1'b0; fast_flag <= 1'b0;
      op_first <= 1'b0; block_total <= '0;
    end else if (step) begin
      phase <= phase_next; seq <= seq_next; byte_count <= byte_count_next;
      resend_count <= resend_count_next; poll_count <= poll_count_next;
      reset_tries <= reset_tries_next; r1_hold <= r1_hold_next;
      elapsed_ticks <= elapsed_ticks_next; op_ticks <= op_ticks_next;
      command_frame <= command_frame_next; response_bytes <= response_bytes_next;
      resp_len <= resp_len_next; capacity_flag <= capacity_flag_next;
      ready_flag <= ready_flag_next; fast_flag <= fast_flag_next;
      op_first <= op_first_next; block_total <= block_total_next;
    end
  end
  // CSD bytes: payload only, written before use
  always_ff @(posedge clk) begin
    if (step) csd <= csd_next;
  end

  function automatic logic [7:0] fbyte(logic [47:0] f, logic [2:0] i);
    return f[47 - 8*i -: 8];
  endfunction

  always_comb begin
    logic [6:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic        go_cmd, go_end, go_frame, go_finish, go_reset_try, go_token;
    logic [7:0]  r1;
    logic [3:0]  st;
    logic [9:0]  bc1;
    logic        in_csd;
    cmd = '0; arg = '0; crc = '0; go_cmd = 1'b0; go_end = 1'b0; go_frame = 1'b0;
    go_finish = 1'b0; go_reset_try = 1'b0; go_token = 1'b0; r1 = '0; st = '0;
    bc1 = byte_count + 10'd1; in_csd = (seq == sdh_pkg::SQ_CSD);

    phase_next = phase; seq_next = seq; byte_count_next = byte_count;
    resend_count_next = resend_count; poll_count_next = poll_count;
    reset_tries_next = reset_tries; r1_hold_next = r1_hold;
    elapsed_ticks_next = elapsed_ticks; op_ticks_next = op_ticks;
    command_frame_next = command_frame; response_bytes_next = response_bytes;
    resp_len_next = resp_len; capacity_flag_next = capacity_flag;
    ready_flag_next = ready_flag; fast_flag_next = fast_flag;
    op_first_next = op_first; block_total_next = block_total; csd_next = csd;
    o = '0; has = 1'b0;

    // first level: input item
    case (kind)
      sdh_pkg::KIND_START: begin
        if (phase == sdh_pkg::PH_IDLE) begin
          ready_flag_next = 1'b0; fast_flag_next = 1'b0; capacity_flag_next = 1'b0;
          block_total_next = '0; phase_next = sdh_pkg::PH_BOOT; byte_count_next = '0;
          if (boot_bytes != 8'd0) begin
            has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF;
          end else begin
            reset_tries_next = '0; go_reset_try = 1'b1;
          end
        end
      end
      sdh_pkg::KIND_READ: begin
        if (phase == sdh_pkg::PH_IDLE) begin
          if (!ready_flag) begin go_finish = 1'b1; st = sdh_pkg::ST_NOT_READY; end
          else begin
            go_cmd = 1'b1; seq_next = sdh_pkg::SQ_READ; cmd = 7'd17; arg = sector;
          end
        end
      end
      sdh_pkg::KIND_TICK: begin
        elapsed_ticks_next = (elapsed_ticks != MAX24) ? elapsed_ticks + 24'd1 : MAX24;
        op_ticks_next = (op_ticks != MAX24) ? op_ticks + 24'd1 : MAX24;
        if (phase == sdh_pkg::PH_PAUSE && elapsed_ticks_next >= poll_interval) begin
          go_cmd = 1'b1; seq_next = sdh_pkg::SQ_OP_PRE; cmd = 7'd55;
        end
      end
      default: begin
        unique case (phase)
          sdh_pkg::PH_BOOT: begin
            byte_count_next = bc1;
            if (bc1 < 10'(boot_bytes)) begin
              has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF;
            end else begin reset_tries_next = '0; go_reset_try = 1'b1; end
          end
          sdh_pkg::PH_BUSY: begin
            if (rx_byte == 8'hFF) begin resend_count_next = '0; go_frame = 1'b1; end
            else if (elapsed_ticks >= busy_timeout) begin
              go_finish = 1'b1; st = sdh_pkg::ST_BUSY_TO;
            end else begin
              has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
            end
          end
          sdh_pkg::PH_FRAME: begin
            byte_count_next = bc1;
            has = 1'b1; o.send_valid = 1'b1; o.select_active = 1'b1;
            if (bc1 < 10'd6) o.send_byte = fbyte(command_frame, bc1[2:0]);
            else begin
              phase_next = sdh_pkg::PH_POLL; poll_count_next = '0;
              if (retry_limit != 8'd0) o.send_byte = 8'hFF;
              else begin
                has = 1'b0; o = '0; resend_count_next = resend_count + 8'd1;
                if (resend_count + 8'd1 < retry_limit) go_frame = 1'b1;
                else begin go_end = 1'b1; r1 = 8'hFF; end
              end
            end
          end
          sdh_pkg::PH_POLL: begin
            if (rx_byte != 8'hFF) begin
              r1_hold_next = rx_byte; response_bytes_next = '0;
              if (resp_len == 3'd0) begin go_end = 1'b1; r1 = rx_byte; end
              else begin
                phase_next = sdh_pkg::PH_RESP; byte_count_next = '0;
                has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
              end
            end else begin
              poll_count_next = poll_count + 8'd1;
              if (poll_count + 8'd1 < retry_limit) begin
                has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
              end else begin
                resend_count_next = resend_count + 8'd1;
                if (resend_count + 8'd1 < retry_limit) go_frame = 1'b1;
                else begin go_end = 1'b1; r1 = 8'hFF; end
              end
            end
          end
          sdh_pkg::PH_RESP: begin
            response_bytes_next = {response_bytes[23:0], rx_byte};
            byte_count_next = bc1;
            if (bc1 < 10'(resp_len)) begin
              has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
            end else begin go_end = 1'b1; r1 = r1_hold; end
          end
          sdh_pkg::PH_TOKEN: begin
            if (rx_byte == 8'hFE) begin
              phase_next = sdh_pkg::PH_DATA; byte_count_next = '0;
              has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
            end else go_token = 1'b1;
          end
          sdh_pkg::PH_DATA: begin
            has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
            byte_count_next = bc1;
            if (in_csd) csd_next[127 - 8*byte_count[3:0] -: 8] = rx_byte;
            else begin
              o.data_valid = 1'b1; o.data_byte = rx_byte;
              o.data_last = (bc1 == 10'd512);
            end
            if (in_csd ? (bc1 >= 10'd16) : (bc1 == 10'd512)) begin
              phase_next = sdh_pkg::PH_CRC; byte_count_next = '0;
            end
          end
          sdh_pkg::PH_CRC: begin
            byte_count_next = bc1;
            if (bc1 < 10'd2) begin
              has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
            end else begin
              if (in_csd) begin block_total_next = csd_blocks; ready_flag_next = 1'b1; end
              go_finish = 1'b1; st = sdh_pkg::ST_OK;
            end
          end
          default: ;
        endcase
      end
    endcase

    // command completion, one level deep
    if (go_end) begin
      case (seq)
        sdh_pkg::SQ_RESET: begin
          if (r1 == 8'h01) begin
            go_cmd = 1'b1; seq_next = sdh_pkg::SQ_COND; cmd = 7'd8; arg = 32'h1AA;
            crc = 8'h43;
          end else begin reset_tries_next = reset_tries + 8'd1; go_reset_try = 1'b1; end
        end
        sdh_pkg::SQ_COND: begin
          if (r1 == 8'hFF) begin go_finish = 1'b1; st = sdh_pkg::ST_NO_RESP; end
          else if (r1 != 8'h01 || response_bytes_next[11:0] != 12'h1AA) begin
            go_finish = 1'b1; st = sdh_pkg::ST_CHECK_FAIL;
          end else begin
            op_first_next = 1'b1; go_cmd = 1'b1; seq_next = sdh_pkg::SQ_OP_PRE; cmd = 7'd55;
          end
        end
        sdh_pkg::SQ_OP_PRE: begin
          go_cmd = 1'b1; seq_next = sdh_pkg::SQ_OP; cmd = 7'd41; arg = 32'h4000_0000;
        end
        sdh_pkg::SQ_OP: begin
          if (op_first) begin op_ticks_next = '0; op_first_next = 1'b0; end
          if (r1 == 8'h00) begin go_cmd = 1'b1; seq_next = sdh_pkg::SQ_OCR; cmd = 7'd58; end
          else if (r1 != 8'h01) begin
            go_finish = 1'b1; st = (r1 == 8'hFF) ? sdh_pkg::ST_NO_RESP : sdh_pkg::ST_OP_FAIL;
          end else if ((op_first ? 24'd0 : op_ticks) >= busy_timeout) begin
            go_finish = 1'b1; st = sdh_pkg::ST_OP_FAIL;
          end else if (poll_interval == 24'd0) begin
            go_cmd = 1'b1; seq_next = sdh_pkg::SQ_OP_PRE; cmd = 7'd55;
          end else begin phase_next = sdh_pkg::PH_PAUSE; elapsed_ticks_next = '0; end
        end
        sdh_pkg::SQ_OCR: begin
          if (r1 != 8'h00) begin
            go_finish = 1'b1; st = (r1 == 8'hFF) ? sdh_pkg::ST_NO_RESP : sdh_pkg::ST_REJECTED;
          end else begin
            capacity_flag_next = response_bytes_next[30];
            go_cmd = 1'b1; seq_next = sdh_pkg::SQ_DET_PRE; cmd = 7'd55;
          end
        end
        sdh_pkg::SQ_DET_PRE: begin
          go_cmd = 1'b1; seq_next = sdh_pkg::SQ_DET; cmd = 7'd42;
        end
        sdh_pkg::SQ_DET: begin
          if (r1 != 8'h00) begin
            go_finish = 1'b1; st = (r1 == 8'hFF) ? sdh_pkg::ST_NO_RESP : sdh_pkg::ST_REJECTED;
          end else begin
            go_cmd = 1'b1; seq_next = sdh_pkg::SQ_BLKLEN; cmd = 7'd16; arg = 32'd512;
          end
        end
        sdh_pkg::SQ_BLKLEN: begin
          if (r1 != 8'h00) begin
            go_finish = 1'b1; st = (r1 == 8'hFF) ? sdh_pkg::ST_NO_RESP : sdh_pkg::ST_REJECTED;
          end else begin
            fast_flag_next = 1'b1; go_cmd = 1'b1; seq_next = sdh_pkg::SQ_CSD; cmd = 7'd9;
          end
        end
        default: begin
          if (r1 != 8'h00) begin
            go_finish = 1'b1; st = (r1 == 8'hFF) ? sdh_pkg::ST_NO_RESP : sdh_pkg::ST_REJECTED;
          end else begin
            phase_next = sdh_pkg::PH_TOKEN; elapsed_ticks_next = '0; byte_count_next = '0;
            if (token_timeout == 24'd0) begin go_finish = 1'b1; st = sdh_pkg::ST_TOKEN_TO; end
            else begin
              has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
            end
          end
        end
      endcase
    end

    // CMD0 retry
    if (go_reset_try) begin
      if (reset_tries_next < retry_limit) begin
        go_cmd = 1'b1; seq_next = sdh_pkg::SQ_RESET; cmd = 7'd0; crc = 8'h4A;
      end else begin go_finish = 1'b1; st = sdh_pkg::ST_RESET_FAIL; end
    end

    // frame start (resend)
    if (go_frame) begin
      if (resend_count_next < retry_limit) begin
        phase_next = sdh_pkg::PH_FRAME; byte_count_next = '0;
        has = 1'b1; o.send_valid = 1'b1; o.send_byte = fbyte(command_frame, 3'd0);
        o.select_active = 1'b1;
      end else begin
        // silent command: CMD55 continues and CMD0 is retried, others end
        case (seq)
          sdh_pkg::SQ_RESET: begin
            reset_tries_next = reset_tries + 8'd1;
            if (reset_tries + 8'd1 < retry_limit) begin
              go_cmd = 1'b1; seq_next = sdh_pkg::SQ_RESET; cmd = 7'd0; crc = 8'h4A;
            end else begin go_finish = 1'b1; st = sdh_pkg::ST_RESET_FAIL; end
          end
          sdh_pkg::SQ_OP_PRE: begin
            go_cmd = 1'b1; seq_next = sdh_pkg::SQ_OP; cmd = 7'd41; arg = 32'h4000_0000;
          end
          sdh_pkg::SQ_DET_PRE: begin
            go_cmd = 1'b1; seq_next = sdh_pkg::SQ_DET; cmd = 7'd42;
          end
          sdh_pkg::SQ_OP: begin
            if (op_first) begin op_ticks_next = '0; op_first_next = 1'b0; end
            go_finish = 1'b1; st = sdh_pkg::ST_NO_RESP;
          end
          default: begin go_finish = 1'b1; st = sdh_pkg::ST_NO_RESP; end
        endcase
      end
    end

    // token wait
    if (go_token) begin
      if (elapsed_ticks >= token_timeout) begin go_finish = 1'b1; st = sdh_pkg::ST_TOKEN_TO; end
      else begin
        has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
      end
    end

    // new command: frame built, busy wait begins with a read
    if (go_cmd) begin
      command_frame_next = {2'b01, cmd[5:0], arg, crc[6:0], 1'b1};
      case (cmd)
        7'd8, 7'd58: resp_len_next = 3'd4;
        default:     resp_len_next = 3'd0;
      endcase
      phase_next = sdh_pkg::PH_BUSY; elapsed_ticks_next = '0;
      has = 1'b1; o.send_valid = 1'b1; o.send_byte = 8'hFF; o.select_active = 1'b1;
    end

    if (go_finish) begin
      phase_next = sdh_pkg::PH_IDLE; has = 1'b1; o.send_valid = 1'b0; o.send_byte = '0;
      o.select_active = 1'b0; o.done_res = 1'b1; o.status = st;
    end

    o.card_blocks = block_total_next;
    o.high_capacity = capacity_flag_next;
    o.fast_clock = fast_flag_next;
  end

  assign res_has = has;
  assign res = o;

  `SDH_ASSERT_IMP(a_done_idle, step && res_has && res.done_res, phase_next == sdh_pkg::PH_IDLE)
  `SDH_ASSERT_IMP(a_one_kind, step && res_has, !(res.send_valid && res.done_res))
  `SDH_ASSERT_IMP(a_ready_has_size, $rose(ready_flag), fast_flag)
endmodule
`default_nettype wire

>>> sv/sdh_out_buf.sv
// Two-entry skid buffer for result beats.
// Depends on sdh_pkg.
`default_nettype none
module sdh_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire sdh_pkg::result_t in_data,
  output logic                  space,
  output logic                  out_valid,
  output sdh_pkg::result_t      out_data,
  input  wire logic             out_ready
);
  sdh_pkg::result_t mem [2];
  logic [1:0] count;
  logic wp, rp;
  logic push, pop;

  assign push = in_valid;
  assign pop = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data = mem[rp];
  // room for one more beat even if nothing drains this cycle
  assign space = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; wp <= 1'b0; rp <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> sv/sd_card_spi_host_controller_core.sv
// SD card SPI-mode host controller, byte level.
// Channels: in (kind, sector, rx_byte), out (result beat), cfg (register writes).
// Each accepted in beat gives zero or one out beat, in order.
// Each result is registered in the output buffer and leaves it in order.
// Throughput: one item per cycle while in_ready; sequencer closes each in one pass.
// A two-entry output buffer sits between sequencer and out channel; in_ready drops
// only when that buffer holds two beats, which takes a stall by the receiver.
// Reset (rst, synchronous): phase idle, counters and size cleared, registers to
// defaults (retry 10, busy 1000000, token 100000, poll 10000, boot 100).
// Start runs init; read streams 512 data bytes; done beats carry a status.
// cfg is always ready; write only while idle.
`default_nettype none
module sd_card_spi_host_controller_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] sector,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             send_valid,
  output logic [7:0]       send_byte,
  output logic             select_active,
  output logic             data_valid,
  output logic [7:0]       data_byte,
  output logic             data_last,
  output logic             done_res,
  output logic [3:0]       status,
  output logic [38:0]      card_blocks,
  output logic             high_capacity,
  output logic             fast_clock
);
  logic step, has, space;
  sdh_pkg::result_t res, q;

  assign cfg_ready = 1'b1;
  assign in_ready = space;
  assign step = in_valid && in_ready;

  sdh_seq u_seq (
    .clk, .rst, .step, .kind, .sector, .rx_byte,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .res_has(has), .res
  );

  sdh_out_buf u_buf (
    .clk, .rst, .in_valid(step && has), .in_data(res), .space,
    .out_valid, .out_data(q), .out_ready
  );

  assign send_valid = q.send_valid;
  assign send_byte = q.send_byte;
  assign select_active = q.select_active;
  assign data_valid = q.data_valid;
  assign data_byte = q.data_byte;
  assign data_last = q.data_last;
  assign done_res = q.done_res;
  assign status = q.status;
  assign card_blocks = q.card_blocks;
  assign high_capacity = q.high_capacity;
  assign fast_clock = q.fast_clock;
endmodule
`default_nettype wire
